/* rtl/spp_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the stride prefetch predictor.
// No dependencies; every other file but spp_ram uses it by scoped names.
package spp_pkg;

  // Table depth is a power of two, at least 2.
  localparam int TABLE_ENTRIES = 256;
  localparam int ADDR_BITS     = 48;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int STRIDE_W      = ADDR_BITS + 1;
  localparam int TGT_W         = ADDR_BITS + 2;
  localparam int QDEPTH        = 2;
  localparam int QPTR_W        = $clog2(QDEPTH);
  localparam logic [ADDR_BITS-1:0] MAX_ADDR_RST = {ADDR_BITS{1'b1}};

  typedef logic [ADDR_BITS-1:0] addr_t;
  typedef logic [STRIDE_W-1:0]  stride_t;
  typedef logic [IDX_W-1:0]     idx_t;

  typedef enum logic [1:0] {
    CONF_INITIAL   = 2'd0,
    CONF_TRANSIENT = 2'd1,
    CONF_STEADY    = 2'd2,
    CONF_NOPRED    = 2'd3
  } conf_t;

  typedef struct packed {
    addr_t   tag;
    addr_t   last_addr;
    stride_t stride;
    conf_t   conf;
  } entry_t;

  typedef struct packed {
    idx_t  idx;
    addr_t pc;
    addr_t addr;
  } req_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

/* rtl/spp_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for access words and prefetch words.
// Depends on spp_pkg.
interface spp_req_if;
  logic                valid;
  logic                ready;
  spp_pkg::addr_t      instr_addr;
  spp_pkg::addr_t      access_addr;
  modport source (output valid, output instr_addr, output access_addr, input ready);
  modport sink   (input valid, input instr_addr, input access_addr, output ready);
endinterface

interface spp_rsp_if;
  logic                valid;
  logic                ready;
  logic                prefetch_valid;
  spp_pkg::addr_t      prefetch_addr;
  modport source (output valid, output prefetch_valid, output prefetch_addr, input ready);
  modport sink   (input valid, input prefetch_valid, input prefetch_addr, output ready);
endinterface

/* rtl/spp_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module spp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/spp_front.sv */
`timescale 1ns / 1ps
// Front end: accepts access words, derives the table index, queues them.
// Depends on spp_pkg and spp_if.
module spp_front (
  input  logic            clk,
  input  logic            rst_n,
  spp_req_if.sink         in_ch,
  output logic            q_valid,
  input  logic            q_ready,
  output spp_pkg::req_t   q_word
);

  spp_pkg::req_t                 slot_r [spp_pkg::QDEPTH];
  logic [spp_pkg::QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [spp_pkg::QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [spp_pkg::QPTR_W:0]      cnt_r, cnt_nxt;
  logic                          push, pop;
  spp_pkg::req_t                 word_in;

  assign in_ch.ready = (cnt_r != (spp_pkg::QPTR_W+1)'(spp_pkg::QDEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (cnt_r != '0);
  assign pop         = q_valid && q_ready;
  assign q_word      = slot_r[rd_ptr_r];

  always_comb begin
    word_in.idx  = in_ch.instr_addr[spp_pkg::IDX_W-1:0];
    word_in.pc   = in_ch.instr_addr;
    word_in.addr = in_ch.access_addr;
    wr_ptr_nxt   = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt   = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt      = cnt_r + (spp_pkg::QPTR_W+1)'(push) - (spp_pkg::QPTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= word_in;
    end
  end

endmodule

/* rtl/spp_back.sv */
`timescale 1ns / 1ps
// Back end: reads the stride table, advances the confidence machine,
// writes the entry back and registers the prefetch word.
// Depends on spp_pkg, spp_if and spp_ram.
module spp_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  spp_pkg::addr_t         cfg_wdata,
  input  logic                   q_valid,
  output logic                   q_ready,
  input  spp_pkg::req_t          q_word,
  spp_rsp_if.source              out_ch
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t                        state_r;
  spp_pkg::req_t                 cur_r;
  logic                          out_valid_r;
  logic                          pf_valid_r;
  spp_pkg::addr_t                pf_addr_r;
  spp_pkg::addr_t                max_r;
  logic [spp_pkg::TABLE_ENTRIES-1:0] valid_r;

  logic                          pop, go, wr_en;
  logic [spp_pkg::ENTRY_W-1:0]   rd_data;
  spp_pkg::entry_t               ent, ent_nxt;
  spp_pkg::stride_t              stride_new;
  logic [spp_pkg::TGT_W-1:0]     target;
  logic                          hit, match, in_range, fetch;

  assign q_ready = (state_r == S_IDLE);
  assign pop     = q_valid && q_ready;
  assign go      = (state_r == S_EXEC) && (!out_valid_r || out_ch.ready);
  assign wr_en   = go;
  assign ent     = spp_pkg::entry_t'(rd_data);

  spp_ram #(
    .WIDTH (spp_pkg::ENTRY_W),
    .DEPTH (spp_pkg::TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (cur_r.idx),
    .wdata (ent_nxt),
    .re    (pop),
    .raddr (q_word.idx),
    .rdata (rd_data)
  );

  always_comb begin
    hit        = valid_r[cur_r.idx] && (ent.tag == cur_r.pc);
    stride_new = {1'b0, cur_r.addr} - {1'b0, ent.last_addr};
    match      = (stride_new == ent.stride);
    target     = {2'b00, cur_r.addr} + {2'b00, cur_r.addr} - {2'b00, ent.last_addr};
    in_range   = !target[spp_pkg::TGT_W-1] &&
                 (target[spp_pkg::ADDR_BITS:0] <= {1'b0, max_r});
    fetch      = hit && (ent.conf != spp_pkg::CONF_NOPRED) && in_range;

    ent_nxt.tag       = cur_r.pc;
    ent_nxt.last_addr = cur_r.addr;
    ent_nxt.stride    = ent.stride;
    ent_nxt.conf      = ent.conf;
    if (!hit) begin
      ent_nxt.stride = '0;
      ent_nxt.conf   = spp_pkg::CONF_INITIAL;
    end else begin
      case (ent.conf)
        spp_pkg::CONF_INITIAL: begin
          if (match) begin
            ent_nxt.conf = spp_pkg::CONF_STEADY;
          end else begin
            ent_nxt.conf   = spp_pkg::CONF_TRANSIENT;
            ent_nxt.stride = stride_new;
          end
        end
        spp_pkg::CONF_TRANSIENT: begin
          if (match) begin
            ent_nxt.conf = spp_pkg::CONF_STEADY;
          end else begin
            ent_nxt.conf   = spp_pkg::CONF_NOPRED;
            ent_nxt.stride = stride_new;
          end
        end
        spp_pkg::CONF_STEADY: begin
          if (!match) begin
            ent_nxt.conf = spp_pkg::CONF_INITIAL;
          end
        end
        default: begin
          if (match) begin
            ent_nxt.conf = spp_pkg::CONF_TRANSIENT;
          end else begin
            ent_nxt.stride = stride_new;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (pop) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (go) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
      if (go) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (pop) begin
      cur_r <= q_word;
    end
    if (go) begin
      pf_valid_r <= fetch;
      pf_addr_r  <= fetch ? target[spp_pkg::ADDR_BITS-1:0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[cur_r.idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= spp_pkg::MAX_ADDR_RST;
    end else if (cfg_we) begin
      max_r <= cfg_wdata;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.prefetch_valid = pf_valid_r;
  assign out_ch.prefetch_addr  = pf_addr_r;

`ifndef SYNTHESIS
  a_out_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EXEC))
    else $error("result word raised outside the update step");

  a_nofetch_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !pf_valid_r |-> (pf_addr_r == '0))
    else $error("prefetch address not cleared without prefetch");

  a_valid_after_write: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(wr_en) |-> valid_r[$past(cur_r.idx)])
    else $error("table entry written but not marked valid");

  a_read_then_write: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> $past(pop) || $past(state_r == S_EXEC))
    else $error("table write without a preceding read");
`endif

endmodule

/* rtl/stride_prefetch_predictor.sv */
`timescale 1ns / 1ps
// Stride prefetch predictor: one prefetch word per accepted access word.
// Path: front queue, table read on accept, update step, then the registered output word.
// The back end takes a new word only after the table write-back of the last one.
// A 2-deep queue decouples input acceptance from the table update.
// Reset: synchronous, clears all valid bits at once; max address all ones.
// Depends on spp_pkg, spp_if, spp_front and spp_back.
module stride_prefetch_predictor (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  spp_pkg::addr_t  cfg_wdata,
  spp_req_if.sink         in_ch,
  spp_rsp_if.source       out_ch
);

  logic            q_valid;
  logic            q_ready;
  spp_pkg::req_t   q_word;

  spp_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_word  (q_word)
  );

  spp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_word    (q_word),
    .out_ch    (out_ch)
  );

endmodule
